/* sv/qrq_pkg.sv */
// Shared types and constants for the Q16.48 requantiser with statistics.
`default_nettype none
package qrq_pkg;

  // Fraction bits of the input format
  localparam int FRAC_BITS = 48;
  localparam int DROP_W    = 6;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [47:0] CNT_MAX = {48{1'b1}};
  localparam logic [63:0] POS_MAX = {1'b0, {63{1'b1}}};

  // One classified item as handed from front to back
  typedef struct packed {
    logic [63:0] rounded_value;
    logic        saturated;
    logic [47:0] abs_delta;
    logic [63:0] grid_index;
    logic        clear_stats;
    logic        changed;
    logic        orig_zero;
    logic        quant_zero;
  } qrq_entry_t;

endpackage
`default_nettype wire

/* sv/qrq_front.sv */
// Front part: accepts items, rounds them and classifies the result.
`default_nettype none
module qrq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [5:0]        frac_bits,
  input  wire logic [63:0]       value_in,
  input  wire logic              clear_stats,
  input  wire logic              item_valid,
  output logic                   item_stall,
  output qrq_pkg::qrq_entry_t    entry,
  output logic                   entry_valid,
  input  wire logic              entry_full
);
  import qrq_pkg::*;

  // Stage valids and handshake chain
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready   = !s3_valid || !entry_full;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_stall = !s1_ready;

  // Bits dropped, from the clamped register
  logic [DROP_W-1:0] bits_kept;
  logic [DROP_W-1:0] drop_in;

  assign bits_kept = (frac_bits > DROP_W'(FRAC_BITS)) ? DROP_W'(FRAC_BITS) : frac_bits;
  assign drop_in   = DROP_W'(FRAC_BITS) - bits_kept;

  // Stage 1 registers
  logic [63:0]       s1_v;
  logic              s1_clr;
  logic [DROP_W-1:0] s1_drop;

  // Stage 1 logic: round half away from zero in one add
  logic [63:0] quantum;
  logic [63:0] half;
  logic [63:0] addend;
  logic [63:0] summ;
  logic        sat1;
  logic [63:0] res1;

  always_comb begin
    quantum = 64'd1 << s1_drop;
    half    = quantum >> 1;
    addend  = s1_v[63] ? (half - 64'd1) : half;
    summ    = (s1_v + addend) & ~(quantum - 64'd1);
    sat1    = (s1_drop != '0) && !s1_v[63] && summ[63];
    if (s1_drop == '0) begin
      res1 = s1_v;
    end else if (sat1) begin
      res1 = POS_MAX;
    end else begin
      res1 = summ;
    end
  end

  // Stage 2 registers
  logic [63:0]       s2_v;
  logic [63:0]       s2_res;
  logic              s2_sat;
  logic              s2_clr;
  logic [DROP_W-1:0] s2_drop;

  // Stage 2 logic: error and grid index (the result is on the grid unless saturated, so the shift is exact there)
  logic [63:0] diff2;
  logic [63:0] grid2;

  assign diff2 = s2_v - s2_res;
  assign grid2 = $unsigned($signed(s2_res) >>> s2_drop);

  // Stage 3 registers
  logic [63:0] s3_v;
  logic [63:0] s3_res;
  logic        s3_sat;
  logic        s3_clr;
  logic [63:0] s3_diff;
  logic [63:0] s3_grid;

  // Stage 3 logic: magnitude of error, clamp to 48 bits, classify
  logic [63:0] mag3;

  always_comb begin
    mag3                = s3_diff[63] ? (~s3_diff + 64'd1) : s3_diff;
    entry.rounded_value = s3_res;
    entry.saturated     = s3_sat;
    entry.abs_delta     = (|mag3[63:48]) ? CNT_MAX : mag3[47:0];
    entry.grid_index    = s3_grid;
    entry.clear_stats   = s3_clr;
    entry.changed       = (s3_res != s3_v);
    entry.orig_zero     = (s3_v == '0);
    entry.quant_zero    = (s3_res == '0);
  end

  assign entry_valid = s3_valid;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= item_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (item_valid && s1_ready) begin
      s1_v    <= value_in;
      s1_clr  <= clear_stats;
      s1_drop <= drop_in;
    end
    if (s1_valid && s2_ready) begin
      s2_v    <= s1_v;
      s2_res  <= res1;
      s2_sat  <= sat1;
      s2_clr  <= s1_clr;
      s2_drop <= s1_drop;
    end
    if (s2_valid && s3_ready) begin
      s3_v    <= s2_v;
      s3_res  <= s2_res;
      s3_sat  <= s2_sat;
      s3_clr  <= s2_clr;
      s3_diff <= diff2;
      s3_grid <= grid2;
    end
  end

endmodule
`default_nettype wire

/* sv/qrq_fifo.sv */
// Short queue of classified items between front and back.
`default_nettype none
module qrq_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  wire qrq_pkg::qrq_entry_t push_data,
  output logic                   full,
  output logic                   pop_valid,
  output qrq_pkg::qrq_entry_t    pop_data,
  input  wire logic              pop
);
  import qrq_pkg::*;

  qrq_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

/* sv/qrq_back.sv */
// Back part: updates running statistics and holds the result register.
`default_nettype none
module qrq_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              entry_valid,
  input  wire qrq_pkg::qrq_entry_t entry,
  output logic                   entry_pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [63:0]            rounded_value,
  output logic                   saturated,
  output logic [47:0]            abs_delta,
  output logic [63:0]            grid_index,
  output logic [47:0]            changed_total,
  output logic [47:0]            orig_zero_total,
  output logic [47:0]            quant_zero_total,
  output logic [47:0]            sat_total,
  output logic [47:0]            max_delta_seen,
  output logic [63:0]            delta_sum,
  output logic [63:0]            grid_low,
  output logic [63:0]            grid_high
);
  import qrq_pkg::*;

  // Saturating 48-bit count
  function automatic logic [47:0] bump48(input logic [47:0] c, input logic inc);
    return (inc && (c != CNT_MAX)) ? (c + 48'd1) : c;
  endfunction

  // Statistics registers
  logic [47:0] changed_count;
  logic [47:0] orig_zero_count;
  logic [47:0] quant_zero_count;
  logic [47:0] sat_count;
  logic [47:0] max_delta_reg;
  logic [63:0] delta_accum;
  logic [63:0] grid_min_reg;
  logic [63:0] grid_max_reg;
  logic        seen_any;

  // Take the next item when the result register is free or being emptied
  assign entry_pop = entry_valid && (!result_valid || !result_stall);

  // Next statistics, from cleared or held values
  logic [47:0] b_changed, b_orig, b_quant, b_sat, b_max;
  logic [63:0] b_accum, b_min, b_maxg;
  logic        b_seen;
  logic [64:0] accum_sum;
  logic [47:0] changed_count_next, orig_zero_count_next, quant_zero_count_next;
  logic [47:0] sat_count_next, max_delta_reg_next;
  logic [63:0] delta_accum_next, grid_min_reg_next, grid_max_reg_next;

  always_comb begin
    b_changed = entry.clear_stats ? '0 : changed_count;
    b_orig    = entry.clear_stats ? '0 : orig_zero_count;
    b_quant   = entry.clear_stats ? '0 : quant_zero_count;
    b_sat     = entry.clear_stats ? '0 : sat_count;
    b_max     = entry.clear_stats ? '0 : max_delta_reg;
    b_accum   = entry.clear_stats ? '0 : delta_accum;
    b_min     = entry.clear_stats ? '0 : grid_min_reg;
    b_maxg    = entry.clear_stats ? '0 : grid_max_reg;
    b_seen    = entry.clear_stats ? 1'b0 : seen_any;

    changed_count_next    = bump48(b_changed, entry.changed);
    orig_zero_count_next  = bump48(b_orig, entry.orig_zero);
    quant_zero_count_next = bump48(b_quant, entry.quant_zero);
    sat_count_next        = bump48(b_sat, entry.saturated);
    max_delta_reg_next    = (entry.abs_delta > b_max) ? entry.abs_delta : b_max;

    accum_sum        = {1'b0, b_accum} + {17'd0, entry.abs_delta};
    delta_accum_next = accum_sum[64] ? {64{1'b1}} : accum_sum[63:0];

    // First item after a clear sets both bounds
    if (!b_seen) begin
      grid_min_reg_next = entry.grid_index;
      grid_max_reg_next = entry.grid_index;
    end else begin
      grid_min_reg_next = ($signed(entry.grid_index) < $signed(b_min)) ?
                          entry.grid_index : b_min;
      grid_max_reg_next = ($signed(entry.grid_index) > $signed(b_maxg)) ?
                          entry.grid_index : b_maxg;
    end
  end

  // Control state and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid     <= 1'b0;
      changed_count    <= '0;
      orig_zero_count  <= '0;
      quant_zero_count <= '0;
      sat_count        <= '0;
      max_delta_reg    <= '0;
      delta_accum      <= '0;
      grid_min_reg     <= '0;
      grid_max_reg     <= '0;
      seen_any         <= 1'b0;
    end else begin
      if (entry_pop) begin
        result_valid     <= 1'b1;
        changed_count    <= changed_count_next;
        orig_zero_count  <= orig_zero_count_next;
        quant_zero_count <= quant_zero_count_next;
        sat_count        <= sat_count_next;
        max_delta_reg    <= max_delta_reg_next;
        delta_accum      <= delta_accum_next;
        grid_min_reg     <= grid_min_reg_next;
        grid_max_reg     <= grid_max_reg_next;
        seen_any         <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (entry_pop) begin
      rounded_value <= entry.rounded_value;
      saturated     <= entry.saturated;
      abs_delta     <= entry.abs_delta;
      grid_index    <= entry.grid_index;
    end
  end

  // Totals change only when a new result is loaded
  assign changed_total    = changed_count;
  assign orig_zero_total  = orig_zero_count;
  assign quant_zero_total = quant_zero_count;
  assign sat_total        = sat_count;
  assign max_delta_seen   = max_delta_reg;
  assign delta_sum        = delta_accum;
  assign grid_low         = grid_min_reg;
  assign grid_high        = grid_max_reg;

endmodule
`default_nettype wire

/* sv/q16_48_requantize_with_stats_top.sv */
// An accepted item passes 3 front stages and 1 queue hop, then loads the result register;
// one item per cycle is taken while the back side drains, so throughput is 1 item/cycle.
// The front rounding pipeline and the 4-entry queue decouple input stall from output stall.
// The statistics update in the back part, done as each result is loaded, sets the sustained rate.
// Reset (synchronous, active high) empties the pipeline and queue, clears all statistics
// and sets frac_bits to 48.
`default_nettype none
module q16_48_requantize_with_stats_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        frac_bits_write,
  input  wire logic [5:0]  frac_bits,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [63:0] value_in,
  input  wire logic        clear_stats,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [63:0]      rounded_value,
  output logic             saturated,
  output logic [47:0]      abs_delta,
  output logic [63:0]      grid_index,
  output logic [47:0]      changed_total,
  output logic [47:0]      orig_zero_total,
  output logic [47:0]      quant_zero_total,
  output logic [47:0]      sat_total,
  output logic [47:0]      max_delta_seen,
  output logic [63:0]      delta_sum,
  output logic [63:0]      grid_low,
  output logic [63:0]      grid_high
);
  import qrq_pkg::*;

  // Configuration register
  logic [5:0] frac_bits_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits_reg <= 6'(FRAC_BITS);
    end else if (frac_bits_write) begin
      frac_bits_reg <= frac_bits;
    end
  end

  qrq_entry_t f_entry;
  logic       f_valid;
  logic       q_full;
  qrq_entry_t q_entry;
  logic       q_valid;
  logic       q_pop;

  qrq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frac_bits   (frac_bits_reg),
    .value_in    (value_in),
    .clear_stats (clear_stats),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .entry       (f_entry),
    .entry_valid (f_valid),
    .entry_full  (q_full)
  );

  qrq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_data  (f_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_data   (q_entry),
    .pop        (q_pop)
  );

  qrq_back u_back (
    .clk              (clk),
    .rst              (rst),
    .entry_valid      (q_valid),
    .entry            (q_entry),
    .entry_pop        (q_pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .rounded_value    (rounded_value),
    .saturated        (saturated),
    .abs_delta        (abs_delta),
    .grid_index       (grid_index),
    .changed_total    (changed_total),
    .orig_zero_total  (orig_zero_total),
    .quant_zero_total (quant_zero_total),
    .sat_total        (sat_total),
    .max_delta_seen   (max_delta_seen),
    .delta_sum        (delta_sum),
    .grid_low         (grid_low),
    .grid_high        (grid_high)
  );

endmodule
`default_nettype wire

/* test/tb_q16_48_requantize_with_stats_top.sv */
// Self-checking testbench for the Q16.48 requantiser with running statistics.

// One result item, field by field, at the block's widths
typedef struct packed {
  logic [63:0] rounded;
  logic        sat;
  logic [47:0] abs_err;
  logic [63:0] grid;
  logic [47:0] changed_cnt;
  logic [47:0] orig_zero_cnt;
  logic [47:0] quant_zero_cnt;
  logic [47:0] sat_cnt;
  logic [47:0] peak_err;
  logic [63:0] err_sum;
  logic [63:0] grid_lo;
  logic [63:0] grid_hi;
} requant_result_t;

// Rounding and statistics predictor plus the queue of results still due
class requant_tracker;
  logic [5:0]      frac_reg;
  logic [47:0]     changed_cnt, orig_zero_cnt, quant_zero_cnt, sat_cnt, peak_err;
  logic [63:0]     err_sum, grid_lo, grid_hi;
  bit              have_grid;
  requant_result_t results_due[$];
  int unsigned     errors;

  function new();
    frac_reg = 6'd48;
    clear_totals();
    errors = 0;
  endfunction

  function void clear_totals();
    changed_cnt    = '0;
    orig_zero_cnt  = '0;
    quant_zero_cnt = '0;
    sat_cnt        = '0;
    peak_err       = '0;
    err_sum        = '0;
    grid_lo        = '0;
    grid_hi        = '0;
    have_grid      = 1'b0;
  endfunction

  function void set_frac(logic [5:0] f);
    frac_reg = f;
  endfunction

  function int outstanding();
    return results_due.size();
  endfunction

  // 48-bit count that holds at all ones
  function logic [47:0] bump(logic [47:0] c, bit inc);
    if (inc && c != qrq_pkg::CNT_MAX) return c + 48'd1;
    return c;
  endfunction

  // Works out the result of one accepted item and queues it
  function void take_word(logic [63:0] v, logic clr);
    int unsigned     dropped;
    int unsigned     kept;
    logic [63:0]     mag, quantum, mask, base, rnd, res, err, grid, gmag;
    bit              neg, sat;
    requant_result_t want;
    kept = (frac_reg > qrq_pkg::FRAC_BITS) ? qrq_pkg::FRAC_BITS : frac_reg;
    dropped = qrq_pkg::FRAC_BITS - kept;
    neg = v[63];
    mag = neg ? (~v + 64'd1) : v;
    res = v;
    sat = 1'b0;
    if (dropped != 0) begin
      quantum = 64'd1 << dropped;
      mask = quantum - 64'd1;
      base = mag & ~mask;
      rnd = base;
      // halves go away from zero on the magnitude
      if ((mag & mask) >= (quantum >> 1))
        rnd = (base > ~64'd0 - quantum) ? ~64'd0 : base + quantum;
      if (neg) begin
        if (rnd >= {1'b1, 63'd0}) begin
          sat = (rnd > {1'b1, 63'd0});
          res = {1'b1, 63'd0};
        end else begin
          res = ~rnd + 64'd1;
        end
      end else if (rnd > qrq_pkg::POS_MAX) begin
        sat = 1'b1;
        res = qrq_pkg::POS_MAX;
      end else begin
        res = rnd;
      end
    end

    if ($signed(v) < $signed(res)) err = res - v;
    else err = v - res;
    if (err > {16'd0, qrq_pkg::CNT_MAX}) err = {16'd0, qrq_pkg::CNT_MAX};

    // grid index truncates toward zero
    if (res[63]) begin
      gmag = (~res + 64'd1) >> dropped;
      grid = ~gmag + 64'd1;
    end else begin
      grid = res >> dropped;
    end

    if (clr) clear_totals();
    changed_cnt    = bump(changed_cnt, res != v);
    orig_zero_cnt  = bump(orig_zero_cnt, v == 64'd0);
    quant_zero_cnt = bump(quant_zero_cnt, res == 64'd0);
    sat_cnt        = bump(sat_cnt, sat);
    if (err[47:0] > peak_err) peak_err = err[47:0];
    err_sum = (err_sum > ~64'd0 - err) ? ~64'd0 : err_sum + err;
    if (!have_grid) begin
      grid_lo = grid;
      grid_hi = grid;
      have_grid = 1'b1;
    end else begin
      if ($signed(grid) < $signed(grid_lo)) grid_lo = grid;
      if ($signed(grid_hi) < $signed(grid)) grid_hi = grid;
    end

    want.rounded        = res;
    want.sat            = sat;
    want.abs_err        = err[47:0];
    want.grid           = grid;
    want.changed_cnt    = changed_cnt;
    want.orig_zero_cnt  = orig_zero_cnt;
    want.quant_zero_cnt = quant_zero_cnt;
    want.sat_cnt        = sat_cnt;
    want.peak_err       = peak_err;
    want.err_sum        = err_sum;
    want.grid_lo        = grid_lo;
    want.grid_hi        = grid_hi;
    results_due.push_back(want);
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endtask

  task check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Compares one accepted result with the oldest one due
  task check_result(requant_result_t got);
    requant_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result item with none due");
    end else begin
      want = results_due.pop_front();
      check_field("rounded_value", got.rounded, want.rounded);
      check_field("saturated", 64'(got.sat), 64'(want.sat));
      check_field("abs_delta", 64'(got.abs_err), 64'(want.abs_err));
      check_field("grid_index", got.grid, want.grid);
      check_field("changed_total", 64'(got.changed_cnt), 64'(want.changed_cnt));
      check_field("orig_zero_total", 64'(got.orig_zero_cnt), 64'(want.orig_zero_cnt));
      check_field("quant_zero_total", 64'(got.quant_zero_cnt),
                  64'(want.quant_zero_cnt));
      check_field("sat_total", 64'(got.sat_cnt), 64'(want.sat_cnt));
      check_field("max_delta_seen", 64'(got.peak_err), 64'(want.peak_err));
      check_field("delta_sum", got.err_sum, want.err_sum);
      check_field("grid_low", got.grid_lo, want.grid_lo);
      check_field("grid_high", got.grid_hi, want.grid_hi);
    end
  endtask
endclass

module tb_q16_48_requantize_with_stats_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qrq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TIE_BURST_ITEMS = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frac_write = 1'b0;
  logic [5:0]  frac_value = 6'd0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [63:0] value_in = 64'd0;
  logic        clear_stats = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [63:0] rounded_value;
  logic        saturated;
  logic [47:0] abs_delta;
  logic [63:0] grid_index;
  logic [47:0] changed_total, orig_zero_total, quant_zero_total, sat_total;
  logic [47:0] max_delta_seen;
  logic [63:0] delta_sum, grid_low, grid_high;

  requant_tracker  tracker;
  requant_result_t seen;
  logic [5:0]      cur_frac = 6'd48;
  bit              send_idle = 1'b1;
  bit              recv_idle = 1'b1;
  int unsigned     cycle_count = 0;

  q16_48_requantize_with_stats_top dut (
    .clk              (clk),
    .rst              (rst),
    .frac_bits_write  (frac_write),
    .frac_bits        (frac_value),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .value_in         (value_in),
    .clear_stats      (clear_stats),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .rounded_value    (rounded_value),
    .saturated        (saturated),
    .abs_delta        (abs_delta),
    .grid_index       (grid_index),
    .changed_total    (changed_total),
    .orig_zero_total  (orig_zero_total),
    .quant_zero_total (quant_zero_total),
    .sat_total        (sat_total),
    .max_delta_seen   (max_delta_seen),
    .delta_sum        (delta_sum),
    .grid_low         (grid_low),
    .grid_high        (grid_high)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stall before each item taken while recv_idle is set
  initial begin
    int unsigned hold;
    forever begin
      hold = recv_idle ? $urandom_range(0, 3) : 0;
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(negedge clk); while (result_valid !== 1'b1);
      @(posedge clk);
    end
  end

  // Sample results at the falling edge ahead of the edge that takes them
  always @(negedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      seen.rounded        = rounded_value;
      seen.sat            = saturated;
      seen.abs_err        = abs_delta;
      seen.grid           = grid_index;
      seen.changed_cnt    = changed_total;
      seen.orig_zero_cnt  = orig_zero_total;
      seen.quant_zero_cnt = quant_zero_total;
      seen.sat_cnt        = sat_total;
      seen.peak_err       = max_delta_seen;
      seen.err_sum        = delta_sum;
      seen.grid_lo        = grid_low;
      seen.grid_hi        = grid_high;
      tracker.check_result(seen);
    end
  end

  // Offers one item and returns at the edge that takes it
  task automatic send_item(logic [63:0] v, logic clr);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    value_in    <= v;
    clear_stats <= clr;
    do @(negedge clk); while (item_stall !== 1'b0);
    tracker.take_word(v, clr);
    @(posedge clk);
  endtask

  // Sender holds off until every result due has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic write_frac(logic [5:0] f);
    frac_write <= 1'b1;
    frac_value <= f;
    @(posedge clk);
    frac_write <= 1'b0;
    cur_frac = f;
    tracker.set_frac(f);
  endtask

  // Random word biased toward rounding ties, extremes and saturation
  function automatic logic [63:0] random_word();
    int unsigned drop;
    logic [63:0] w, half;
    drop = 48 - ((cur_frac > 6'd48) ? 48 : cur_frac);
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        w = 64'($urandom_range(0, 2000));
        if ($urandom_range(0, 1) == 1) w = -w;
      end
      1, 2: begin
        if (drop != 0) begin
          half = 64'd1 << (drop - 1);
          w = (w & ~((64'd1 << drop) - 64'd1)) | half;
          if ($urandom_range(0, 1) == 1) w = w - 64'd1;
        end
      end
      3: begin
        case ($urandom_range(0, 5))
          0: w = POS_MAX;
          1: w = {1'b1, 63'd0};
          2: w = {1'b1, 62'd0, 1'b1};
          3: w = POS_MAX - 64'd1;
          4: w = 64'd1;
          default: w = ~64'd0;
        endcase
      end
      4: w = 64'd0;
      5: begin
        w = {1'b0, 15'h7fff, w[47:0]};
        if ($urandom_range(0, 1) == 1) w = -w;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Stimulus
  initial begin
    logic [5:0]  phase_frac;
    logic [63:0] tie_word;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting keeps every bit
    send_item(POS_MAX, 1'b0);
    send_item({1'b1, 63'd0}, 1'b0);
    send_item({$urandom, $urandom}, 1'b0);
    send_item(64'd0, 1'b1);
    drain_results();

    // coarsest grid: ties, extremes, clamp and the most negative word
    write_frac(6'd0);
    send_item(64'd0, 1'b1);
    send_item(64'd1, 1'b0);
    send_item(~64'd0, 1'b0);
    send_item(64'h0000_8000_0000_0000, 1'b0);
    send_item(64'hffff_8000_0000_0000, 1'b0);
    send_item(64'h0000_7fff_ffff_ffff, 1'b0);
    send_item(64'hffff_8000_0000_0001, 1'b0);
    send_item(POS_MAX, 1'b0);
    send_item({1'b1, 63'd0}, 1'b0);
    send_item({1'b1, 62'd0, 1'b1}, 1'b0);
    send_item(64'h7fff_7fff_ffff_ffff, 1'b1);
    send_item(64'h7fff_8000_0000_0000, 1'b0);
    send_item(64'h8000_8000_0000_0000, 1'b0);
    send_item(64'h8000_7fff_ffff_ffff, 1'b0);
    drain_results();

    // register above range behaves as full precision
    write_frac(6'd63);
    send_item(POS_MAX, 1'b0);
    send_item({1'b1, 63'd0}, 1'b1);
    send_item(64'h0000_8000_0000_0000, 1'b0);
    drain_results();

    // random phases over several grid settings
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: phase_frac = 6'd1;
        1: phase_frac = 6'd47;
        2: phase_frac = 6'd24;
        3: phase_frac = 6'd16;
        4: phase_frac = 6'd0;
        5: phase_frac = 6'd48;
        6: phase_frac = 6'd63;
        7: phase_frac = 6'd8;
        default: phase_frac = 6'($urandom_range(0, 63));
      endcase
      write_frac(phase_frac);
      send_idle = (p % 3 != 1) && (p != 6);
      recv_idle = (p % 3 != 2) && (p != 6);
      for (int i = 0; i < 105; i++) begin
        if (p == 4 && i == 50) drain_results();
        send_item(random_word(), $urandom_range(0, 31) == 0);
      end
      drain_results();
    end

    // back-to-back burst of ties with the largest error
    write_frac(6'd0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int i = 0; i < TIE_BURST_ITEMS; i++) begin
      tie_word = {16'($urandom_range(0, 16'h7ffe)), 48'h8000_0000_0000};
      if ($urandom_range(0, 1) == 1) tie_word = -tie_word;
      send_item(tie_word, i == 0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
